[sv/tqlu_pkg.sv]
// Package for the tabular Q-learning update core: field widths, defaults,
// register indexes and the controller-to-datapath command bundle.
// No dependencies; every other file of the core refers to it by scoped names.
`default_nettype none

package tqlu_pkg;

    // Default geometry, handed down as top-level parameter defaults
    localparam int GRID_ROWS_DEF    = 16;
    localparam int GRID_COLS_DEF    = 16;
    localparam int ACTION_COUNT_DEF = 4;

    // Fixed port widths
    localparam int POS_W    = 4;
    localparam int ACTION_W = 2;
    localparam int PCT_W    = 7;
    localparam int GAIN_W   = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IX_W = 2;

    // Arithmetic widths: Q7.8 value, gamma product, difference, alpha product, sum
    localparam int Q_W = 16;
    localparam int P_W = 26;
    localparam int D_W = 27;
    localparam int U_W = 36;
    localparam int N_W = 21;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_LEARN_RATE      = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_DISCOUNT        = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_EXPLORE_PERCENT = 2'd2;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] LEARN_RATE_RST      = 9'd26;
    localparam logic [GAIN_W-1:0] DISCOUNT_RST        = 9'd230;
    localparam logic [PCT_W-1:0]  EXPLORE_PERCENT_RST = 7'd20;

    // Request type codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;   // capture the transaction and read both table rows
        logic sel;    // pick the action, form gamma*maxQ, take old Q
        logic diff;   // form the temporal difference
        logic mul;    // scale by alpha
        logic wb;     // round, saturate and write the row back
        logic step;   // current transaction is a learning step
    } tqlu_cmd_t;

endpackage

`default_nettype wire

[sv/tqlu_ctrl.sv]
// Sequencer of the Q-learning update core: one state per datapath step, load issued from idle.
// Depends on tqlu_pkg for the command bundle and request codes.
`default_nettype none

module tqlu_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              req_type,
    output logic                   busy,
    output logic                   done,
    output tqlu_pkg::tqlu_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEL  = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_step_reg;
    logic       is_step_next;
    logic       done_reg;
    logic       done_next;

    // Advance through the steps of one transaction
    always_comb
    begin
        state_next   = state_reg;
        is_step_next = is_step_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next   = S_SEL;
                    is_step_next = (req_type == tqlu_pkg::REQ_STEP);
                end
            end
            S_SEL:
            begin
                if (is_step_reg)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_DIFF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_step_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_step_reg <= is_step_next;
            done_reg    <= done_next;
        end
    end

    // Drive commands and status
    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && start;
        cmd.sel  = (state_reg == S_SEL);
        cmd.diff = (state_reg == S_DIFF);
        cmd.mul  = (state_reg == S_MUL);
        cmd.wb   = (state_reg == S_WB);
        cmd.step = is_step_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    // A result shows only once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("tqlu_ctrl: result strobe while busy");

    // An accepted transaction starts with the selection step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_SEL))
        else $error("tqlu_ctrl: accepted transaction not started");

    // A learning step goes on to the update, a start ends with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL && is_step_reg) |=> (state_reg == S_DIFF && !done_reg))
        else $error("tqlu_ctrl: learning step skipped its update");

    // Write-back is followed by exactly one result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |=> (done_reg && state_reg == S_IDLE))
        else $error("tqlu_ctrl: write-back not followed by result");
`endif

endmodule

`default_nettype wire

[sv/tqlu_dp.sv]
// Datapath of the Q-learning update core: Q table memory with row valid
// bits, configuration registers, greedy/explore choice and the update math.
// Depends on tqlu_pkg; driven by tqlu_ctrl through tqlu_pkg::tqlu_cmd_t.
`default_nettype none

module tqlu_dp
#(
    parameter int GRID_ROWS    = tqlu_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS    = tqlu_pkg::GRID_COLS_DEF,
    parameter int ACTION_COUNT = tqlu_pkg::ACTION_COUNT_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tqlu_pkg::tqlu_cmd_t                   cmd,
    input  wire logic                                  cfg_we,
    input  wire logic        [tqlu_pkg::CFG_IX_W-1:0]  cfg_index,
    input  wire logic        [tqlu_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic        [tqlu_pkg::POS_W-1:0]     pos_row,
    input  wire logic        [tqlu_pkg::POS_W-1:0]     pos_col,
    input  wire logic signed [tqlu_pkg::Q_W-1:0]       reward,
    input  wire logic        [tqlu_pkg::PCT_W-1:0]     rand_percent,
    input  wire logic        [tqlu_pkg::ACTION_W-1:0]  rand_action,
    output logic             [tqlu_pkg::ACTION_W-1:0]  action
);

    localparam int POS_SPAN  = 2 ** tqlu_pkg::POS_W;
    localparam int ACT_SPAN  = 2 ** tqlu_pkg::ACTION_W;
    // Only positions reachable through the ports occupy the table
    localparam int ROWS_USED = (GRID_ROWS < POS_SPAN) ? GRID_ROWS : POS_SPAN;
    localparam int COLS_USED = (GRID_COLS < POS_SPAN) ? GRID_COLS : POS_SPAN;
    localparam int DEPTH     = ROWS_USED * COLS_USED;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ACT_W     = $clog2(ACTION_COUNT);
    localparam int Q_W       = tqlu_pkg::Q_W;
    localparam int ROW_W     = ACTION_COUNT * Q_W;
    localparam int P_W       = tqlu_pkg::P_W;
    localparam int D_W       = tqlu_pkg::D_W;
    localparam int U_W       = tqlu_pkg::U_W;
    localparam int N_W       = tqlu_pkg::N_W;
    localparam int RND_SH    = 16;

    localparam logic signed [U_W-1:0] RND_HALF = U_W'(signed'(33'sd32768));
    localparam logic signed [N_W-1:0] SAT_HI   = N_W'(signed'(17'sd32767));
    localparam logic signed [N_W-1:0] SAT_LO   = N_W'(-17'sd32768);

    // Configuration registers
    logic [tqlu_pkg::GAIN_W-1:0] learn_rate_reg;
    logic [tqlu_pkg::GAIN_W-1:0] discount_reg;
    logic [tqlu_pkg::PCT_W-1:0]  explore_percent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg      <= tqlu_pkg::LEARN_RATE_RST;
            discount_reg        <= tqlu_pkg::DISCOUNT_RST;
            explore_percent_reg <= tqlu_pkg::EXPLORE_PERCENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tqlu_pkg::CFG_LEARN_RATE:
                    learn_rate_reg <= cfg_data[tqlu_pkg::GAIN_W-1:0];
                tqlu_pkg::CFG_DISCOUNT:
                    discount_reg <= cfg_data[tqlu_pkg::GAIN_W-1:0];
                tqlu_pkg::CFG_EXPLORE_PERCENT:
                    explore_percent_reg <= cfg_data[tqlu_pkg::PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Wrap tables for position and random action
    logic [tqlu_pkg::POS_W-1:0] row_wrap [POS_SPAN];
    logic [tqlu_pkg::POS_W-1:0] col_wrap [POS_SPAN];
    logic [ACT_W-1:0]           act_wrap [ACT_SPAN];

    for (genvar i = 0; i < POS_SPAN; i++)
    begin : g_pos_wrap
        assign row_wrap[i] = tqlu_pkg::POS_W'(i % GRID_ROWS);
        assign col_wrap[i] = tqlu_pkg::POS_W'(i % GRID_COLS);
    end

    for (genvar i = 0; i < ACT_SPAN; i++)
    begin : g_act_wrap
        assign act_wrap[i] = ACT_W'(i % ACTION_COUNT);
    end

    logic [ADDR_W-1:0] cur_addr_next;
    assign cur_addr_next = ADDR_W'(ADDR_W'(row_wrap[pos_row]) * ADDR_W'(COLS_USED)
                                   + ADDR_W'(col_wrap[pos_col]));

    // Episode state
    logic [ADDR_W-1:0] last_addr_reg;
    logic [ACT_W-1:0]  last_action_reg;
    logic [ACT_W-1:0]  action_next;
    logic [ADDR_W-1:0] cur_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_addr_reg   <= '0;
            last_action_reg <= '0;
        end
        else if (cmd.sel)
        begin
            last_addr_reg   <= cur_addr_reg;
            last_action_reg <= action_next;
        end
    end

    // Q table and row valid bits
    logic [ROW_W-1:0]  mem_q [DEPTH];
    logic [DEPTH-1:0]  row_valid_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  prev_row_reg;
    logic              cur_valid_reg;
    logic              prev_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [ACT_W-1:0]  wb_lane_reg;
    logic [ROW_W-1:0]  wb_row;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_row_reg  <= mem_q[cur_addr_next];
            prev_row_reg <= mem_q[last_addr_reg];
        end
        if (cmd.wb)
        begin
            mem_q[wb_addr_reg] <= wb_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.wb)
        begin
            row_valid_reg[wb_addr_reg] <= 1'b1;
        end
    end

    // Capture the transaction
    logic signed [Q_W-1:0]            reward_reg;
    logic [tqlu_pkg::PCT_W-1:0]       rand_percent_reg;
    logic [ACT_W-1:0]                 rand_action_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_valid_reg    <= row_valid_reg[cur_addr_next];
            prev_valid_reg   <= row_valid_reg[last_addr_reg];
            cur_addr_reg     <= cur_addr_next;
            wb_addr_reg      <= last_addr_reg;
            wb_lane_reg      <= last_action_reg;
            reward_reg       <= reward;
            rand_percent_reg <= rand_percent;
            rand_action_reg  <= act_wrap[rand_action];
        end
    end

    // Split rows into lanes; a row never written reads as zero
    logic signed [Q_W-1:0] cur_q  [ACTION_COUNT];
    logic signed [Q_W-1:0] prev_q [ACTION_COUNT];

    for (genvar a = 0; a < ACTION_COUNT; a++)
    begin : g_lane
        assign cur_q[a]  = cur_valid_reg  ? $signed(cur_row_reg[a*Q_W +: Q_W])  : '0;
        assign prev_q[a] = prev_valid_reg ? $signed(prev_row_reg[a*Q_W +: Q_W]) : '0;
    end

    // Greedy pick: highest index wins on ties
    logic [ACT_W-1:0] best;

    always_comb
    begin
        best = '0;
        for (int a = 1; a < ACTION_COUNT; a++)
        begin
            if (cur_q[a] >= cur_q[best])
            begin
                best = ACT_W'(a);
            end
        end
    end

    logic explore;
    assign explore     = cmd.step && (rand_percent_reg < explore_percent_reg);
    assign action_next = explore ? rand_action_reg : best;

    // Selection step: result action, gamma*maxQ, old Q
    logic [ACT_W-1:0]      action_reg;
    logic signed [P_W-1:0] p1_reg;
    logic signed [P_W-1:0] p1_next;
    logic signed [Q_W-1:0] qold_reg;

    assign p1_next = P_W'(signed'({1'b0, discount_reg})) * P_W'(cur_q[best]);

    always_ff @(posedge clk)
    begin
        if (cmd.sel)
        begin
            action_reg <= action_next;
            p1_reg     <= p1_next;
            qold_reg   <= prev_q[wb_lane_reg];
        end
    end

    assign action = tqlu_pkg::ACTION_W'(action_reg);

    // Difference step: reward*256 + gamma*maxQ - Q*256
    logic signed [D_W-1:0] d_reg;
    logic signed [D_W-1:0] d_next;

    assign d_next = D_W'($signed({reward_reg, 8'h00})) + D_W'(p1_reg)
                  - D_W'($signed({qold_reg, 8'h00}));

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            d_reg <= d_next;
        end
    end

    // Scale step: alpha * difference
    logic signed [U_W-1:0] u_reg;
    logic signed [U_W-1:0] u_next;

    assign u_next = U_W'(signed'({1'b0, learn_rate_reg})) * U_W'(d_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            u_reg <= u_next;
        end
    end

    // Write-back step: round half up, add, saturate, merge into row
    logic signed [U_W-1:0] u_rnd;
    logic signed [N_W-1:0] q_sum;
    logic signed [Q_W-1:0] q_sat;

    assign u_rnd = u_reg + RND_HALF;
    assign q_sum = N_W'(qold_reg) + N_W'($signed(u_rnd[U_W-1:RND_SH]));

    always_comb
    begin
        if (q_sum > SAT_HI)
        begin
            q_sat = SAT_HI[Q_W-1:0];
        end
        else if (q_sum < SAT_LO)
        begin
            q_sat = SAT_LO[Q_W-1:0];
        end
        else
        begin
            q_sat = q_sum[Q_W-1:0];
        end
    end

    always_comb
    begin
        wb_row = prev_valid_reg ? prev_row_reg : '0;
        for (int a = 0; a < ACTION_COUNT; a++)
        begin
            if (ACT_W'(a) == wb_lane_reg)
            begin
                wb_row[a*Q_W +: Q_W] = q_sat;
            end
        end
    end

endmodule

`default_nettype wire

[sv/tabular_q_learning_update_core.sv]
// Top level of the tabular Q-learning update core.
// Instantiates tqlu_ctrl and tqlu_dp; uses tqlu_pkg for widths and defaults.
`default_nettype none

// A transaction is taken at a rising edge with start high and busy low. A
// start request (req_type 0) records the position and returns the greedy
// action after the selection step; a learning step (req_type 1) returns its
// action once the sequencer has read the table, formed gamma*maxQ, the
// difference, the alpha product and written the updated Q value back. The
// result appears on action for one cycle with done high and must be taken
// then; busy is already low in that cycle, so the next transaction may be
// accepted at the same edge. The table is cleared by reset through per-row
// valid bits, with no clearing pass. Configuration is to be written with
// cfg_we, cfg_index and cfg_data while busy is low; the core does not enforce it.
module tabular_q_learning_update_core
#(
    parameter int GRID_ROWS    = tqlu_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS    = tqlu_pkg::GRID_COLS_DEF,
    parameter int ACTION_COUNT = tqlu_pkg::ACTION_COUNT_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  req_type,
    input  wire logic        [tqlu_pkg::POS_W-1:0]     pos_row,
    input  wire logic        [tqlu_pkg::POS_W-1:0]     pos_col,
    input  wire logic signed [tqlu_pkg::Q_W-1:0]       reward,
    input  wire logic        [tqlu_pkg::PCT_W-1:0]     rand_percent,
    input  wire logic        [tqlu_pkg::ACTION_W-1:0]  rand_action,
    output logic                                       done,
    output logic             [tqlu_pkg::ACTION_W-1:0]  action,
    input  wire logic                                  cfg_we,
    input  wire logic        [tqlu_pkg::CFG_IX_W-1:0]  cfg_index,
    input  wire logic        [tqlu_pkg::CFG_W-1:0]     cfg_data
);

    tqlu_pkg::tqlu_cmd_t cmd;

    // Sequencer
    tqlu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    // Table, configuration and arithmetic
    tqlu_dp
    #(
        .GRID_ROWS    (GRID_ROWS),
        .GRID_COLS    (GRID_COLS),
        .ACTION_COUNT (ACTION_COUNT)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_row      (pos_row),
        .pos_col      (pos_col),
        .reward       (reward),
        .rand_percent (rand_percent),
        .rand_action  (rand_action),
        .action       (action)
    );

endmodule

`default_nettype wire
